// ----- sv/ptts_pkg.sv -----
// Shared types and constants for the periodic task tick scheduler.
`timescale 1ns / 1ps
`default_nettype none
package ptts_pkg;

  localparam int KIND_W     = 2;
  localparam int TASK_IDX_W = 4;
  localparam int FIELD_W    = 16;
  localparam int MASK_W     = 12;
  localparam int SLOT_ID_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK     = 2'd0,
    KIND_DISPATCH = 2'd1,
    KIND_CREATE   = 2'd2
  } kind_t;

  typedef struct packed {
    logic                  do_tick;
    logic                  do_dispatch;
    logic                  do_create;
    logic [TASK_IDX_W-1:0] task_index;
    logic                  start_running;
  } cell_ctrl_t;

  typedef struct packed {
    logic hi;
    logic lo;
  } seek_t;

endpackage
`default_nettype wire

// ----- sv/ptts_cell.sv -----
// One task slot: created flag, reload interval, countdown, ready flag and pick chain stage.
`timescale 1ns / 1ps
`default_nettype none
module ptts_cell import ptts_pkg::*; #(
  parameter int COUNT_WIDTH = 16,
  parameter int PTR_W       = 4,
  parameter int INDEX       = 0
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cell_ctrl_t             ctrl,
  input  wire logic [PTR_W-1:0]       scan_pointer,
  input  wire logic [COUNT_WIDTH-1:0] interval_value,
  input  wire logic [COUNT_WIDTH-1:0] start_delay,
  input  wire seek_t                  seek_in,
  output seek_t                       seek_out,
  input  wire logic                   any_hi,
  output logic                        picked,
  output logic                        accepted,
  output logic                        ready_next
);

  logic                   created;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] interval;
  logic [COUNT_WIDTH-1:0] countdown;

  logic                   created_next;
  logic [COUNT_WIDTH-1:0] interval_next;
  logic [COUNT_WIDTH-1:0] countdown_next;
  logic                   cand;
  logic                   geq;
  logic                   hit_hi;
  logic                   hit_lo;
  logic                   match;

  assign cand   = created & ready;
  assign geq    = scan_pointer <= PTR_W'(INDEX);
  assign hit_hi = seek_in.hi & cand & geq;
  assign hit_lo = seek_in.lo & cand;

  // Pass the search on unless this slot takes it.
  assign seek_out.hi = seek_in.hi & ~(cand & geq);
  assign seek_out.lo = seek_in.lo & ~cand;

  assign match    = SLOT_ID_W'(ctrl.task_index) == SLOT_ID_W'(INDEX);
  assign picked   = ctrl.do_dispatch & (any_hi ? hit_hi : hit_lo);
  assign accepted = ctrl.do_create & match & ~created;

  always_comb begin
    created_next   = created;
    ready_next     = ready;
    interval_next  = interval;
    countdown_next = countdown;
    if (ctrl.do_tick && countdown != '0) begin
      if (countdown == COUNT_WIDTH'(1)) begin
        countdown_next = interval;
        ready_next     = 1'b1;
      end else begin
        countdown_next = countdown - COUNT_WIDTH'(1);
      end
    end
    if (picked) begin
      ready_next = 1'b0;
    end
    if (accepted) begin
      created_next   = 1'b1;
      interval_next  = interval_value;
      countdown_next = start_delay;
      ready_next     = ctrl.start_running;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      created   <= 1'b0;
      ready     <= 1'b0;
      countdown <= '0;
    end else begin
      created   <= created_next;
      ready     <= ready_next;
      countdown <= countdown_next;
    end
  end

  always_ff @(posedge clk) begin
    interval <= interval_next;
  end

endmodule
`default_nettype wire

// ----- sv/periodic_task_tick_scheduler.sv -----
// Top level of the periodic task tick scheduler: slot cells, pick encoder, result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request per beat: a tick that
//   steps every running countdown, a dispatch that picks the next ready task in
//   round-robin order, or a create that fills an empty slot.
//   Output channel (out_valid / out_stall) returns exactly one result per request:
//   task_valid and picked_task for a dispatch, create_accepted for a create, and
//   the ready_mask of slots 0 to 11 after the request in every case.
//   The result is registered at the edge after acceptance. One request per cycle
//   is taken unless a held result stalls; every slot cell updates in parallel and
//   the round-robin pick ripples through the cell chain in the same cycle, so the
//   chain length (TASK_SLOTS cells) sets the critical path.
//   While the receiver stalls a held result, the input stalls too and all slot
//   state holds; a request is taken in the same cycle the held result leaves.
//   Synchronous reset clears every slot (not created, not ready, countdown zero),
//   the scan pointer and the output valid flag (the result payload is not reset).
`timescale 1ns / 1ps
`default_nettype none
module periodic_task_tick_scheduler import ptts_pkg::*; #(
  parameter int TASK_SLOTS  = 12,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [KIND_W-1:0]     kind,
  input  wire logic [TASK_IDX_W-1:0] task_index,
  input  wire logic [FIELD_W-1:0]    interval_value,
  input  wire logic [FIELD_W-1:0]    start_delay,
  input  wire logic                  start_running,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       task_valid,
  output logic [TASK_IDX_W-1:0]      picked_task,
  output logic [MASK_W-1:0]          ready_mask,
  output logic                       create_accepted
);

  localparam int PTR_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  logic                   go;
  cell_ctrl_t             ctrl;
  logic [COUNT_WIDTH-1:0] itv;
  logic [COUNT_WIDTH-1:0] dly;
  logic [PTR_W-1:0]       scan_pointer;
  logic [PTR_W-1:0]       scan_pointer_next;
  seek_t                  seek [TASK_SLOTS+1];
  logic                   any_hi;
  logic [TASK_SLOTS-1:0]  pick_vec;
  logic [TASK_SLOTS-1:0]  accept_vec;
  logic [TASK_SLOTS-1:0]  ready_vec;
  logic [SLOT_ID_W-1:0]   pick_id;
  logic                   found;
  logic [MASK_W-1:0]      mask_next;

  // Hold the input whenever a finished result is still waiting.
  assign in_stall = out_valid & out_stall;
  assign go       = in_valid & ~in_stall;

  assign ctrl.do_tick       = go & (kind == KIND_TICK);
  assign ctrl.do_dispatch   = go & (kind == KIND_DISPATCH);
  assign ctrl.do_create     = go & (kind == KIND_CREATE);
  assign ctrl.task_index    = task_index;
  assign ctrl.start_running = start_running;

  // Keep the low COUNT_WIDTH bits of the timing fields (zero-extend if wider).
  assign itv = COUNT_WIDTH'(interval_value);
  assign dly = COUNT_WIDTH'(start_delay);

  // Search starts open in both passes: first from the pointer upward, then from slot 0.
  assign seek[0].hi = 1'b1;
  assign seek[0].lo = 1'b1;
  assign any_hi     = ~seek[TASK_SLOTS].hi;

  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    ptts_cell #(
      .COUNT_WIDTH(COUNT_WIDTH),
      .PTR_W      (PTR_W),
      .INDEX      (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .scan_pointer  (scan_pointer),
      .interval_value(itv),
      .start_delay   (dly),
      .seek_in       (seek[i]),
      .seek_out      (seek[i+1]),
      .any_hi        (any_hi),
      .picked        (pick_vec[i]),
      .accepted      (accept_vec[i]),
      .ready_next    (ready_vec[i])
    );
  end

  // Encode the one-hot pick into a slot number.
  always_comb begin
    pick_id = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (pick_vec[i]) begin
        pick_id = pick_id | SLOT_ID_W'(i);
      end
    end
  end

  assign found = |pick_vec;

  // Advance the pointer just past the dispatched slot, wrapping at the last slot.
  always_comb begin
    scan_pointer_next = scan_pointer;
    if (found) begin
      if (pick_id == SLOT_ID_W'(TASK_SLOTS - 1)) begin
        scan_pointer_next = '0;
      end else begin
        scan_pointer_next = PTR_W'(pick_id + SLOT_ID_W'(1));
      end
    end
  end

  // Report only the first twelve slots; missing slots read as not ready.
  for (genvar b = 0; b < MASK_W; b++) begin : g_mask
    if (b < TASK_SLOTS) begin : g_live
      assign mask_next[b] = ready_vec[b];
    end else begin : g_none
      assign mask_next[b] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pointer <= '0;
      out_valid    <= 1'b0;
    end else begin
      scan_pointer <= scan_pointer_next;
      if (go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on every accepted request, hold otherwise.
  always_ff @(posedge clk) begin
    if (go) begin
      task_valid      <= found;
      picked_task     <= TASK_IDX_W'(pick_id);
      ready_mask      <= mask_next;
      create_accepted <= |accept_vec;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ptts_checker.sv -----
// Port-level checker for the periodic task tick scheduler, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module ptts_checker import ptts_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic                  task_valid,
  input wire logic [TASK_IDX_W-1:0] picked_task,
  input wire logic [MASK_W-1:0]     ready_mask,
  input wire logic                  create_accepted
);

  // A held result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ready_mask) && $stable(picked_task))
    else $error("held result changed");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // No dispatch hit means slot number zero.
  a_no_pick: assert property (@(posedge clk) disable iff (rst)
    out_valid && !task_valid |-> picked_task == '0)
    else $error("picked_task set without a dispatched task");

  // A dispatch and a create never report in the same result.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(task_valid && create_accepted))
    else $error("dispatch and create both reported");

  // The dispatched slot shows as no longer ready.
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    out_valid && task_valid && picked_task < TASK_IDX_W'(MASK_W) |-> !ready_mask[picked_task])
    else $error("dispatched slot still ready");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (.*);
`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the periodic task tick scheduler: slot table predictor, random traffic.
`timescale 1ns / 1ps
module tb;
  import ptts_pkg::*;

  localparam int TASK_SLOTS = 12;
  localparam int REQUEST_GOAL = 1600;
  // Kind 3 has no meaning: no state change, only the ready mask comes back.
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

  // One result beat as seen on the output channel.
  typedef struct packed {
    logic                  hit;
    logic [TASK_IDX_W-1:0] slot;
    logic [MASK_W-1:0]     mask;
    logic                  taken;
  } sched_result_t;

  // Slot table predictor plus the queue of results still owed by the block.
  class slot_table_checker;
    bit                    created [TASK_SLOTS];
    bit [FIELD_W-1:0]      reload  [TASK_SLOTS];
    bit [FIELD_W-1:0]      count   [TASK_SLOTS];
    bit                    ready   [TASK_SLOTS];
    int unsigned           scan;
    sched_result_t         pending_results[$];
    int                    mismatch_count;

    function new();
      scan = 0;
      mismatch_count = 0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        created[i] = 1'b0;
        reload[i]  = '0;
        count[i]   = '0;
        ready[i]   = 1'b0;
      end
    endfunction

    // Apply one accepted request to the slot table and queue its result.
    function void note_request(logic [KIND_W-1:0] k, logic [TASK_IDX_W-1:0] idx,
                               logic [FIELD_W-1:0] itv, logic [FIELD_W-1:0] dly,
                               logic run);
      sched_result_t r;
      int unsigned   s;
      r   = '0;
      case (k)
        KIND_TICK: begin
          for (int i = 0; i < TASK_SLOTS; i++) begin
            if (count[i] != 0) begin
              count[i] = count[i] - 1'b1;
              if (count[i] == 0) begin
                count[i] = reload[i];
                ready[i] = 1'b1;
              end
            end
          end
        end
        KIND_DISPATCH: begin
          for (int j = 0; j < TASK_SLOTS; j++) begin
            s = (scan + j) % TASK_SLOTS;
            if (created[s] && ready[s]) begin
              ready[s] = 1'b0;
              r.hit    = 1'b1;
              r.slot   = s[TASK_IDX_W-1:0];
              scan     = (s + 1) % TASK_SLOTS;
              break;
            end
          end
        end
        KIND_CREATE: begin
          if (idx < TASK_SLOTS && !created[idx]) begin
            created[idx] = 1'b1;
            reload[idx]  = itv;
            count[idx]   = dly;
            ready[idx]   = run;
            r.taken      = 1'b1;
          end
        end
        default: ;
      endcase
      for (int i = 0; i < MASK_W; i++) r.mask[i] = ready[i];
      pending_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      mismatch_count++;
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    // Compare one accepted result with the oldest expectation.
    task check_result(sched_result_t got);
      sched_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 16'(got.mask), '0);
        return;
      end
      want = pending_results.pop_front();
      if (got.hit != want.hit)
        report_mismatch("task_valid", 16'(got.hit), 16'(want.hit));
      if (got.slot != want.slot)
        report_mismatch("picked_task", 16'(got.slot), 16'(want.slot));
      if (got.mask != want.mask)
        report_mismatch("ready_mask", 16'(got.mask), 16'(want.mask));
      if (got.taken != want.taken)
        report_mismatch("create_accepted", 16'(got.taken), 16'(want.taken));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [KIND_W-1:0]     kind;
  logic [TASK_IDX_W-1:0] task_index;
  logic [FIELD_W-1:0]    interval_value;
  logic [FIELD_W-1:0]    start_delay;
  logic                  start_running;
  logic                  out_valid;
  logic                  out_stall;
  logic                  task_valid;
  logic [TASK_IDX_W-1:0] picked_task;
  logic [MASK_W-1:0]     ready_mask;
  logic                  create_accepted;

  slot_table_checker sched_check = new();

  // Requests accepted so far, of every kind.
  int  requests_done = 0;
  // While set, both sides run back to back with no idle cycles.
  bit  calm = 1'b0;

  always #5 clk = ~clk;

  periodic_task_tick_scheduler u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .task_index      (task_index),
    .interval_value  (interval_value),
    .start_delay     (start_delay),
    .start_running   (start_running),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .task_valid      (task_valid),
    .picked_task     (picked_task),
    .ready_mask      (ready_mask),
    .create_accepted (create_accepted)
  );

  // Offer one request: idle for a drawn gap, then hold it until the block takes it.
  // Valid stays high across back-to-back requests, so it is never lowered and
  // raised again within one edge.
  task automatic offer(logic [KIND_W-1:0] k, logic [TASK_IDX_W-1:0] idx,
                       logic [FIELD_W-1:0] itv, logic [FIELD_W-1:0] dly, logic run);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    kind           <= k;
    task_index     <= idx;
    interval_value <= itv;
    start_delay    <= dly;
    start_running  <= run;
    // Sample stall as it stood at the edge; accept once it is low.
    do @(posedge clk); while (in_stall);
    sched_check.note_request(k, idx, itv, dly, run);
    requests_done++;
  endtask

  // Mostly small counts so that slots fire often; now and then a wide value.
  function automatic logic [FIELD_W-1:0] draw_count();
    if ($urandom_range(0, 4) == 0) return FIELD_W'($urandom);
    return FIELD_W'($urandom_range(0, 14));
  endfunction

  task automatic send_random();
    int                    pick;
    logic [TASK_IDX_W-1:0] idx;
    logic [FIELD_W-1:0]    itv;
    logic [FIELD_W-1:0]    dly;
    logic                  run;
    pick = $urandom_range(0, 99);
    idx  = TASK_IDX_W'($urandom_range(0, 15));
    itv  = draw_count();
    dly  = draw_count();
    run  = 1'($urandom);
    // Unused fields carry random junk on ticks and dispatches.
    if (pick < 45)      offer(KIND_TICK, idx, itv, dly, run);
    else if (pick < 80) offer(KIND_DISPATCH, idx, itv, dly, run);
    else if (pick < 96) offer(KIND_CREATE, idx, itv, dly, run);
    else                offer(KIND_NOP, idx, itv, dly, run);
  endtask

  // Request side: reset, directed corners, random traffic, then drain.
  initial begin : request_source
    bit paused;
    paused         = 1'b0;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    kind           <= KIND_TICK;
    task_index     <= '0;
    interval_value <= '0;
    start_delay    <= '0;
    start_running  <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Empty table: dispatch finds nothing, tick and kind 3 change nothing.
    offer(KIND_DISPATCH, 4'd0, 16'd0, 16'd0, 1'b0);
    offer(KIND_TICK, 4'd0, 16'd0, 16'd0, 1'b0);
    offer(KIND_NOP, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1);
    // Fill a slot, then try it again: the second create is refused.
    offer(KIND_CREATE, 4'd0, 16'd2, 16'd1, 1'b0);
    offer(KIND_CREATE, 4'd0, 16'd5, 16'd5, 1'b1);
    // Index past the table is refused, including the all-ones index.
    offer(KIND_CREATE, 4'd12, 16'd1, 16'd1, 1'b1);
    offer(KIND_CREATE, 4'd15, 16'hFFFF, 16'hFFFF, 1'b1);
    // Interval zero fires once; start delay zero never counts.
    offer(KIND_CREATE, 4'd3, 16'd0, 16'd2, 1'b0);
    offer(KIND_CREATE, 4'd5, 16'd3, 16'd0, 1'b1);
    offer(KIND_CREATE, 4'd11, 16'hFFFF, 16'hFFFF, 1'b1);
    offer(KIND_CREATE, 4'd7, 16'd1, 16'd1, 1'b1);
    // Step time and drain the ready slots in round-robin order.
    repeat (3) offer(KIND_TICK, 4'd0, 16'd0, 16'd0, 1'b0);
    repeat (5) offer(KIND_DISPATCH, 4'd0, 16'd0, 16'd0, 1'b0);
    offer(KIND_TICK, 4'd0, 16'd0, 16'd0, 1'b0);
    offer(KIND_NOP, 4'd0, 16'd0, 16'd0, 1'b0);
    offer(KIND_DISPATCH, 4'd0, 16'd0, 16'd0, 1'b0);

    while (requests_done < REQUEST_GOAL) begin
      // Run back to back in one window out of five.
      calm = ((requests_done / 150) % 5) == 2;
      // Halfway through, hold off until every owed result has come back.
      if (!paused && requests_done >= REQUEST_GOAL / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (sched_check.pending_results.size() != 0);
      end
      send_random();
    end

    // Drain: wait for the last result, then a few more edges for stray beats.
    in_valid <= 1'b0;
    do @(posedge clk); while (sched_check.pending_results.size() != 0);
    repeat (4) @(posedge clk);
    if (sched_check.mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: check each accepted result, then stall for a drawn number of cycles.
  // Twice it holds off for a long stretch so the block fills and stalls its input.
  initial begin : result_sink
    int            stall_left;
    int            hold_left;
    int            seen;
    sched_result_t got;
    stall_left = 0;
    hold_left  = 0;
    seen       = 0;
    out_stall  <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid && !out_stall) begin
          got.hit   = task_valid;
          got.slot  = picked_task;
          got.mask  = ready_mask;
          got.taken = create_accepted;
          sched_check.check_result(got);
          seen++;
          if (seen == 400 || seen == 1100) hold_left = 250;
          stall_left = calm ? 0 : $urandom_range(0, 13);
        end else if (hold_left > 0) begin
          hold_left--;
        end else if (stall_left > 0) begin
          stall_left--;
        end
        out_stall <= (hold_left != 0) || (stall_left != 0);
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
